[hdl/xrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrs_pkg: shared types and constants of the random number source
// Holds the splitmix64 and request constants, the controller state type and
// the command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package xrs_pkg;

    localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

    // Operation codes of a request; unused codes behave as OP_FULL.
    localparam logic [2:0] OP_FULL     = 3'd0;
    localparam logic [2:0] OP_UPPER    = 3'd1;
    localparam logic [2:0] OP_BELOW    = 3'd2;
    localparam logic [2:0] OP_FRACTION = 3'd3;
    localparam logic [2:0] OP_COIN     = 3'd4;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] MUL_LAST = 5'd2;
    localparam logic [STEP_W-1:0] DIV_LAST = 5'd31;
    localparam logic [1:0]        ROUND_LAST = 2'd3;

    typedef enum logic [3:0] {
        ST_SEED_LOAD,
        ST_MIX_ADD,
        ST_MUL_A,
        ST_MIX_XOR,
        ST_MUL_B,
        ST_MIX_STORE,
        ST_IDLE,
        ST_ADVANCE,
        ST_DIVIDE,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic       load_seed;
        logic       mix_add;
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       mul_sel_b;
        logic       mix_xor;
        logic       store_low;
        logic       store_high;
        logic       take_req;
        logic       advance;
        logic       div_step;
        logic       result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic mix_zero;
        logic skip_advance;
        logic is_below;
        logic out_free;
    } dp_status_t;

endpackage

[hdl/xrs_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrs_req_if: request channel
// Carries valid, ready and the request payload: operation, bound, probability.
// ----------------------------------------------------------------------------
interface xrs_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] bound;
    logic [53:0] probability;

    modport source (output valid, output operation, output bound, output probability,
                    input ready);
    modport sink (input valid, input operation, input bound, input probability,
                  output ready);
endinterface

[hdl/xrs_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrs_rsp_if: result channel
// Carries valid, ready and the 64-bit result value.
// ----------------------------------------------------------------------------
interface xrs_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

[hdl/xrs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrs_ctrl: sequencing controller
// Steps the datapath through splitmix64 seeding, generator advance, the
// radix-4 remainder loop and the hand-off to the output register.
// ----------------------------------------------------------------------------
module xrs_ctrl
    import xrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output ctrl_state_t state
);

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        round_reg, round_next;
    logic              high_reg, high_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SEED_LOAD;
            step_reg  <= '0;
            round_reg <= '0;
            high_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            round_reg <= round_next;
            high_reg  <= high_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        round_next = round_reg;
        high_next  = high_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = !cfg_we;
                if (cfg_we)
                begin
                    state_next = ST_SEED_LOAD;
                end
                else if (req_valid)
                begin
                    cmd.take_req = 1'b1;
                    state_next   = ST_ADVANCE;
                end
            end
            ST_SEED_LOAD:
            begin
                cmd.load_seed = 1'b1;
                round_next    = '0;
                high_next     = 1'b0;
                state_next    = ST_MIX_ADD;
            end
            ST_MIX_ADD:
            begin
                cmd.mix_add = 1'b1;
                step_next   = '0;
                state_next  = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_idx = step_reg[1:0];
                if (step_reg == MUL_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_MIX_XOR;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_MIX_XOR:
            begin
                cmd.mix_xor = 1'b1;
                state_next  = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_idx   = step_reg[1:0];
                cmd.mul_sel_b = 1'b1;
                if (step_reg == MUL_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_MIX_STORE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_MIX_STORE:
            begin
                if (!high_reg)
                begin
                    cmd.store_low = 1'b1;
                    high_next     = 1'b1;
                    state_next    = ST_MIX_ADD;
                end
                else
                begin
                    cmd.store_high = 1'b1;
                    high_next      = 1'b0;
                    if (status.mix_zero && (round_reg != ROUND_LAST))
                    begin
                        round_next = round_reg + 1'b1;
                        state_next = ST_MIX_ADD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ADVANCE:
            begin
                if (status.skip_advance)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    step_next   = '0;
                    state_next  = status.is_below ? ST_DIVIDE : ST_RESULT;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_RESULT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_SEED_LOAD;
            end
        endcase
    end

    assign state = state_reg;

endmodule

[hdl/xrs_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrs_datapath: generator state, seeding arithmetic and result formatting
// Holds the seed, mixer counter and generator words, a shared 32x32
// multiplier for the splitmix64 products, a remainder unit that retires two
// dividend bits per cycle, and the output register.
// ----------------------------------------------------------------------------
module xrs_datapath
    import xrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  logic [2:0]  req_operation,
    input  logic [31:0] req_bound,
    input  logic [53:0] req_probability,
    input  logic        rsp_ready,
    output logic        rsp_valid,
    output logic [63:0] rsp_value,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic        state_zero
);

    logic [63:0] seed_reg;
    logic [63:0] counter_reg;
    logic [63:0] low_reg;
    logic [63:0] high_reg;
    logic [63:0] z_reg;
    logic [63:0] acc_reg;
    logic [63:0] rnd_reg;
    logic [31:0] rem_reg;
    logic [2:0]  op_reg;
    logic [31:0] bound_reg;
    logic [53:0] prob_reg;
    logic [63:0] value_reg;
    logic        out_valid_reg;

    logic [63:0] counter_sum;
    logic [63:0] mul_const;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] prod;
    logic [63:0] acc_next;
    logic [63:0] mix_out;
    logic [63:0] sum_ab;
    logic [63:0] rnd_next;
    logic [63:0] b_x;
    logic [63:0] low_next;
    logic [63:0] high_next;
    logic [31:0] rem_mid;
    logic [31:0] rem_next;
    logic [63:0] result;

    // One restoring step: shift in a dividend bit, subtract when it fits.
    function automatic logic [31:0] rem_step(input logic [31:0] r, input logic b,
                                             input logic [31:0] d);
        logic [32:0] t;
        logic [32:0] diff;
        t    = {r, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
            return diff[31:0];
        else
            return t[31:0];
    endfunction

    assign counter_sum = counter_reg + MIX_GOLDEN;
    assign mul_const   = cmd.mul_sel_b ? MIX_MUL_B : MIX_MUL_A;
    assign mul_x       = (cmd.mul_idx == 2'd1) ? z_reg[63:32] : z_reg[31:0];
    assign mul_y       = (cmd.mul_idx == 2'd2) ? mul_const[63:32] : mul_const[31:0];
    assign prod        = 64'(mul_x) * 64'(mul_y);
    assign acc_next    = (cmd.mul_idx == 2'd0) ? prod : acc_reg + {prod[31:0], 32'h0};
    assign mix_out     = acc_reg ^ (acc_reg >> 31);

    assign sum_ab    = low_reg + high_reg;
    assign rnd_next  = {sum_ab[46:0], sum_ab[63:47]} + low_reg;
    assign b_x       = high_reg ^ low_reg;
    assign low_next  = {low_reg[14:0], low_reg[63:15]} ^ b_x ^ (b_x << 21);
    assign high_next = {b_x[35:0], b_x[63:36]};

    assign rem_mid  = rem_step(rem_reg, rnd_reg[63], bound_reg);
    assign rem_next = rem_step(rem_mid, rnd_reg[62], bound_reg);

    always_comb
    begin
        case (op_reg)
            OP_UPPER:    result = {32'h0, rnd_reg[63:32]};
            OP_BELOW:    result = (bound_reg == 32'h0) ? 64'h0 : {32'h0, rem_reg};
            OP_FRACTION: result = {11'h0, rnd_reg[63:11]};
            OP_COIN:     result = {63'h0, ({1'b0, rnd_reg[63:11]} < prob_reg)};
            default:     result = rnd_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                seed_reg <= cfg_wdata;
            if (cmd.result_load)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_seed)
            counter_reg <= seed_reg;
        else if (cmd.mix_add)
            counter_reg <= counter_sum;
        if (cmd.mix_add)
            z_reg <= counter_sum ^ (counter_sum >> 30);
        else if (cmd.mix_xor)
            z_reg <= acc_reg ^ (acc_reg >> 27);
        if (cmd.mul_en)
            acc_reg <= acc_next;
        if (cmd.store_low)
            low_reg <= mix_out;
        else if (cmd.advance)
            low_reg <= low_next;
        if (cmd.store_high)
            high_reg <= mix_out;
        else if (cmd.advance)
            high_reg <= high_next;
        if (cmd.take_req)
        begin
            op_reg    <= req_operation;
            bound_reg <= req_bound;
            prob_reg  <= req_probability;
        end
        if (cmd.advance)
        begin
            rnd_reg <= rnd_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rnd_reg <= {rnd_reg[61:0], 2'b00};
            rem_reg <= rem_next;
        end
        if (cmd.result_load)
            value_reg <= result;
    end

    assign status.mix_zero     = (mix_out == 64'h0) && (low_reg == 64'h0);
    assign status.skip_advance = (op_reg == OP_BELOW) && (bound_reg == 32'h0);
    assign status.is_below     = (op_reg == OP_BELOW) && (bound_reg != 32'h0);
    assign status.out_free     = !out_valid_reg || rsp_ready;

    assign state_zero = (low_reg == 64'h0) && (high_reg == 64'h0);
    assign rsp_valid  = out_valid_reg;
    assign rsp_value  = value_reg;

endmodule

[hdl/xoroshiro_random_source_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoroshiro_random_source_top: xoroshiro128++ random number source
// Top level joining the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req channel (operation, bound, probability) and one
// result per request leaves on the rsp channel (value); each side moves one
// transaction when valid and ready are both high at a rising clock edge.
// The seed register is to be written through cfg_we and cfg_wdata only
// while the block is idle; the block itself does not enforce this. A write
// in the idle state reseeds the generator through splitmix64 expansion.
// For most operations the request transaction is followed by the advance
// and then the load of the output register, which raises rsp.valid. For a
// below-bound request with a nonzero bound the remainder unit runs between
// the two; it retires two dividend bits per cycle over the whole 64-bit
// random word. The block works on one request at a time: a new request is
// taken in the cycle after the previous result is loaded into the output
// register. Reset reseeds from seed 0. Seeding takes a load step and then,
// per round, two splitmix64 outputs, each of which needs two products built
// from three 32x32 partial products on one shared multiplier; req.ready
// stays low meanwhile. When the receiver stalls, the result waits in the
// output register and the next request may already be taken and computed;
// it waits until the slot frees.
// ----------------------------------------------------------------------------
module xoroshiro_random_source_top
    import xrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    xrs_req_if.sink     req,
    xrs_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata
);

    dp_cmd_t     cmd;
    dp_status_t  status;
    ctrl_state_t state;
    logic        state_zero;
    logic        req_ready;
    logic        rsp_valid;
    logic [63:0] rsp_value;

    xrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd),
        .state     (state)
    );

    xrs_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .req_operation   (req.operation),
        .req_bound       (req.bound),
        .req_probability (req.probability),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp_valid),
        .rsp_value       (rsp_value),
        .cmd             (cmd),
        .status          (status),
        .state_zero      (state_zero)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.value = rsp_value;

    // After a request transaction, req.ready drops while the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while the previous one is in flight");

    // Seeding never leaves the generator in its all-zero state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_IDLE) |-> !state_zero)
        else $error("generator state is all zero while idle");

    // A result is loaded only into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> (!rsp.valid || rsp.ready))
        else $error("result overwrote a pending transaction");

endmodule

[tb/sv/xoroshiro_random_source_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoroshiro_random_source_top_test: self-checking bench for the random source
// Drives requests of every operation through the request channel and rewrites
// the seed register between phases. A scoreboard keeps its own copy of the
// splitmix64 seeding and the xoroshiro128++ state, predicts every result, and
// compares each result transaction in order. Both channel sides stall at
// random with changing rates, ending in a phase at full speed.
// ----------------------------------------------------------------------------
module xoroshiro_random_source_top_test
    import xrs_pkg::*;
();

    // Operation codes 5 to 7 carry no name in the package; the block treats
    // them as a full 64-bit request.
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    // Probability of one, in units of 2^-53, and the largest 54-bit value.
    localparam logic [53:0] PROB_ONE = 54'd1 << 53;
    localparam logic [53:0] PROB_MAX = '1;

    localparam int RANDOM_PER_PHASE = 320;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int TAIL_CYCLES      = 40;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the generator state and queues predicted values.
    // ------------------------------------------------------------------------
    class xrs_value_board;
        logic [63:0] mix_count;
        logic [63:0] word_lo;
        logic [63:0] word_hi;
        logic [63:0] awaited_values[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned op_seen[8];

        task report_mismatch(input string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        function logic [63:0] rotate_left(input logic [63:0] x, input int unsigned k);
            return (x << k) | (x >> (64 - k));
        endfunction

        // One splitmix64 output; the counter keeps advancing across calls.
        function logic [63:0] splitmix_next();
            logic [63:0] z;
            mix_count = mix_count + MIX_GOLDEN;
            z = mix_count;
            z = (z ^ (z >> 30)) * MIX_MUL_A;
            z = (z ^ (z >> 27)) * MIX_MUL_B;
            return z ^ (z >> 31);
        endfunction

        function void reseed(input logic [63:0] seed_value);
            int unsigned rounds;
            rounds = 0;
            mix_count = seed_value;
            do
            begin
                word_lo = splitmix_next();
                word_hi = splitmix_next();
                rounds++;
            end
            while (word_lo == '0 && word_hi == '0 && rounds < 4);
        endfunction

        function logic [63:0] xoro_step();
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] sum;
            a = word_lo;
            b = word_hi;
            sum = rotate_left(a + b, 17) + a;
            b = b ^ a;
            word_lo = rotate_left(a, 49) ^ b ^ (b << 21);
            word_hi = rotate_left(b, 28);
            return sum;
        endfunction

        function void note_request(input logic [2:0] op, input logic [31:0] bnd,
                                   input logic [53:0] prob);
            logic [63:0] v;
            op_seen[op]++;
            case (op)
                OP_UPPER:    v = xoro_step() >> 32;
                OP_BELOW:    v = (bnd == '0) ? 64'd0 : xoro_step() % {32'd0, bnd};
                OP_FRACTION: v = xoro_step() >> 11;
                OP_COIN:     v = ((xoro_step() >> 11) < {10'd0, prob}) ? 64'd1 : 64'd0;
                default:     v = xoro_step();
            endcase
            awaited_values.push_back(v);
        endfunction

        task check_value(input logic [63:0] got);
            logic [63:0] want;
            if (awaited_values.size() == 0)
            begin
                report_mismatch($sformatf("value %h arrived with nothing outstanding", got));
                return;
            end
            want = awaited_values.pop_front();
            checked++;
            if (got !== want)
                report_mismatch($sformatf("result %0d: value %h, predicted %h",
                                          checked, got, want));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [63:0] cfg_wdata;

    // Stall rates in percent, changed between phases by the main sequence.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned seed_writes;

    xrs_value_board board;

    xrs_req_if req_ch ();
    xrs_rsp_if rsp_ch ();

    xoroshiro_random_source_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 50 MHz clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // The receiver decides once per cycle whether it can take a result.
    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Both channels are sampled right at the edge, so the values seen here
    // are the ones the block saw. A request is noted before any result of
    // the same edge is checked; a result always trails its request anyway.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            board.note_request(req_ch.operation, req_ch.bound, req_ch.probability);
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_value(rsp_ch.value);
    end

    // Presents one request and holds it until the block takes it. The call
    // starts and ends just after a rising edge. Before presenting, the sender
    // may idle with valid low, at the rate set by send_idle_pct.
    task automatic send_request(input logic [2:0] op, input logic [31:0] bnd,
                                input logic [53:0] prob);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.bound       <= bnd;
        req_ch.probability <= prob;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
    endtask

    // Random request. Bounds and probabilities lean toward their corner
    // values so that zero bounds, powers of two and saturated coin flips
    // show up often; the rest is uniform, bounds over the full field and probabilities below one.
    task automatic send_random_item();
        logic [2:0]  op;
        logic [31:0] bnd;
        logic [53:0] prob;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 4)
            op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        else
            op = 3'($urandom_range(OP_COIN, OP_FULL));

        pick = $urandom_range(99);
        if (pick < 8)
            bnd = '0;
        else if (pick < 18)
            bnd = $urandom_range(16, 1);
        else if (pick < 26)
            bnd = 32'd1 << $urandom_range(31);
        else if (pick < 30)
            bnd = '1 - $urandom_range(3);
        else
            bnd = $urandom;

        pick = $urandom_range(99);
        if (pick < 8)
            prob = '0;
        else if (pick < 14)
            prob = PROB_ONE;
        else if (pick < 18)
            prob = PROB_ONE | 54'({$urandom, $urandom});
        else if (pick < 26)
            prob = 54'($urandom_range(255));
        else
            prob = 54'({$urandom, $urandom}) & (PROB_ONE - 1);

        send_request(op, bnd, prob);
    endtask

    // Waits until every predicted result has come back, with a bound so a
    // lost result is reported rather than hanging the run.
    task automatic wait_for_results();
        int unsigned cycles;
        cycles = 0;
        while (board.awaited_values.size() != 0 && cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (board.awaited_values.size() != 0)
            board.report_mismatch($sformatf("%0d results still missing after %0d cycles",
                                            board.awaited_values.size(), cycles));
    endtask

    // Seed writes happen only with nothing in flight. The write lands on the
    // next edge; the block then holds req.ready low while it reseeds.
    task automatic load_seed(input logic [63:0] seed_value);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= seed_value;
        @(posedge clk);
        board.reseed(seed_value);
        cfg_we <= 1'b0;
        seed_writes++;
    endtask

    task automatic run_random_phase(input int unsigned count);
        repeat (count)
            send_random_item();
        req_ch.valid <= 1'b0;
    endtask

    initial
    begin
        board = new();
        board.reseed(64'd0);
        seed_writes = 0;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= OP_FULL;
        req_ch.bound       <= '0;
        req_ch.probability <= '0;

        // Sender mostly busy, receiver stalling about half the time.
        send_idle_pct = 7;
        recv_idle_pct = 55;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests on the state seeded by reset. A zero bound must
        // return zero without advancing the generator, so the request after
        // it shows whether the state was left alone.
        send_request(OP_FULL,      32'h0000_0000, '0);
        send_request(OP_UPPER,     32'hFFFF_FFFF, PROB_MAX);
        send_request(OP_BELOW,     32'h0000_0000, '0);
        send_request(OP_FULL,      32'h0000_0000, '0);
        send_request(OP_BELOW,     32'h0000_0001, '0);
        send_request(OP_BELOW,     32'h0000_0002, '0);
        send_request(OP_BELOW,     32'h0000_0003, '0);
        send_request(OP_BELOW,     32'h8000_0000, '0);
        send_request(OP_BELOW,     32'h7FFF_FFFF, '0);
        send_request(OP_BELOW,     32'hFFFF_FFFF, '0);
        send_request(OP_FRACTION,  32'h0000_0000, '0);
        send_request(OP_FRACTION,  32'hFFFF_FFFF, PROB_MAX);
        // Coin flips at never, barely, half, almost sure, sure and beyond.
        send_request(OP_COIN,      32'h0000_0000, '0);
        send_request(OP_COIN,      32'h0000_0000, 54'd1);
        send_request(OP_COIN,      32'h0000_0000, PROB_ONE >> 1);
        send_request(OP_COIN,      32'h0000_0000, PROB_ONE - 1);
        send_request(OP_COIN,      32'h0000_0000, PROB_ONE);
        send_request(OP_COIN,      32'hFFFF_FFFF, PROB_MAX);
        // Unused codes behave as a full-value request.
        send_request(OP_SPARE_LO,  32'h0000_0000, '0);
        send_request(OP_SPARE_MID, 32'h1234_5678, PROB_ONE);
        send_request(OP_SPARE_HI,  32'hFFFF_FFFF, PROB_MAX);
        req_ch.valid <= 1'b0;

        // Phase one: all-ones seed.
        load_seed('1);
        run_random_phase(RANDOM_PER_PHASE);

        // Phase two: random seed, receiver mostly ready, sender stalling.
        load_seed({$urandom, $urandom});
        send_idle_pct = 55;
        recv_idle_pct = 7;
        run_random_phase(RANDOM_PER_PHASE);

        // Phase three: no stalls at all, split between a zero seed written
        // explicitly and another random seed.
        load_seed(64'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(RANDOM_PER_PHASE / 2);
        load_seed({$urandom, $urandom});
        run_random_phase(RANDOM_PER_PHASE / 2);

        // Drain, then leave room for a stray result to show up.
        wait_for_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (board.awaited_values.size() != 0)
            board.report_mismatch($sformatf("%0d predicted results never arrived",
                                            board.awaited_values.size()));

        $display("Checked %0d results under %0d seed writes and three stall profiles.",
                 board.checked, seed_writes);
        $display("Requests: %0d full, %0d upper, %0d bound, %0d fraction, %0d coin, %0d spare.",
                 board.op_seen[OP_FULL], board.op_seen[OP_UPPER], board.op_seen[OP_BELOW],
                 board.op_seen[OP_FRACTION], board.op_seen[OP_COIN],
                 board.op_seen[OP_SPARE_LO] + board.op_seen[OP_SPARE_MID]
                     + board.op_seen[OP_SPARE_HI]);
        if (board.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[xoroshiro_random_source_top.f]
hdl/xrs_pkg.sv
hdl/xrs_req_if.sv
hdl/xrs_rsp_if.sv
hdl/xrs_ctrl.sv
hdl/xrs_datapath.sv
hdl/xoroshiro_random_source_top.sv
tb/sv/xoroshiro_random_source_top_test.sv
